[rtl/efrt_pkg.sv]
// Shared types and constants for the event fragment reassembly table.
package efrt_pkg;

	typedef enum logic [1:0] {
		OP_CHUNK   = 2'd0,
		OP_TICK    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_COMPLETE  = 3'd2,
		ST_REAPED    = 3'd3,
		ST_BAD_INDEX = 3'd4,
		ST_NO_SLOT   = 3'd5,
		ST_RELEASED  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		SLOT_FREE       = 2'd0,
		SLOT_ASSEMBLING = 2'd1,
		SLOT_DONE       = 2'd2
	} slot_st_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_ARRIVE,
		FSM_TICK,
		FSM_RELEASE,
		FSM_OUT
	} fsm_t;

	localparam int unsigned TIMEOUT_RESET = 1000;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] event_id;
		logic [7:0]  chunk_index;
		logic [5:0]  release_slot;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] event_id_res;
		logic [5:0]  slot;
		logic [7:0]  chunk_index_res;
		logic        last;
	} out_item_t;

endpackage

[rtl/efrt_if.sv]
// Valid/ready channel interfaces for input and result items.
interface efrt_in_if;
	logic                valid;
	logic                ready;
	efrt_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface efrt_out_if;
	logic                valid;
	logic                ready;
	efrt_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/efrt_slot_mem.sv]
// Per-slot record memory: id, chunk map and deadline, registered read.
module efrt_slot_mem #(
	parameter int SLOTS = 32,
	parameter int CHUNKS = 16,
	parameter int AW = 5
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [31:0]          wid,
	input  logic [CHUNKS-1:0]    wmap,
	input  logic [31:0]          wdl,
	input  logic [AW-1:0]        raddr,
	output logic [31:0]          rid,
	output logic [CHUNKS-1:0]    rmap,
	output logic [31:0]          rdl
);
	logic [31:0]       id_mem [SLOTS];
	logic [CHUNKS-1:0] map_mem [SLOTS];
	logic [31:0]       dl_mem [SLOTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			id_mem[waddr]  <= wid;
			map_mem[waddr] <= wmap;
			dl_mem[waddr]  <= wdl;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rid  <= id_mem[raddr];
		rmap <= map_mem[raddr];
		rdl  <= dl_mem[raddr];
	end
endmodule

[rtl/event_fragment_reassembly_table_top.sv]
// Top level of the event fragment reassembly table.
// Usage: items enter on in_ch (operation, event_id, chunk_index, release_slot);
// results leave on out_ch, last marking the final result of an item.
// timeout_ticks is written through cfg_we/cfg_wdata; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// A chunk arrival scans the slot records one per cycle through the record
// memory read port and allocates the first free slot if none matches; a
// chunk that joins a slot found in the table rereads that record before
// its result is handed over; a bad chunk index is answered without a scan.
// A tick visits every slot the same way, reading each assembling slot and
// judging its deadline from the read data; while a reaped result waits for
// the receiver, the scan holds. The newest reaped item is held back until
// the scan shows whether it is the last one. A release reads the slot record
// and then frees it. One item is in work at a time.
// Results sit in an output register; while the receiver stalls the block
// holds its result and takes no further item. Reset frees all slots, zeroes
// time and sets timeout_ticks to 1000; the record memory is not cleared, as
// free slots are never read.
module event_fragment_reassembly_table_top #(
	parameter int SLOTS = 32,
	parameter int CHUNKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	efrt_in_if.sink     in_ch,
	efrt_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	efrt_pkg::fsm_t     state_q, state_d;
	efrt_pkg::in_item_t item_q;
	efrt_pkg::slot_st_t sstate_q [SLOTS];
	logic [15:0]        timeout_q;
	logic [31:0]        now_q;
	logic [CW-1:0]      idx_q;       // scan position
	logic               rd_v_q;      // memory data for idx_q-1 valid
	logic [AW-1:0]      rd_a_q;
	logic               found_q, free_v_q;
	logic [AW-1:0]      found_q_a, free_q_a;
	logic               more_q;      // reap_q holds a reaped item not yet shown
	efrt_pkg::out_item_t reap_q;
	efrt_pkg::out_item_t res_q;
	logic               res_v_q;

	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [31:0]        wid, wdl, rid, rdl;
	logic [CHUNKS-1:0]  wmap, rmap;

	efrt_slot_mem #(.SLOTS(SLOTS), .CHUNKS(CHUNKS), .AW(AW)) u_mem (
		.clk, .we, .waddr, .wid, .wmap, .wdl, .raddr, .rid, .rmap, .rdl
	);

	logic               chunk_bad;
	logic [CHUNKS-1:0]  bit_m;
	logic [31:0]        diff;
	logic               rel_ok;
	logic               scan_end;

	assign chunk_bad = ({24'd0, item_q.chunk_index} >= 32'(CHUNKS));
	assign bit_m     = CHUNKS'(1) << item_q.chunk_index[$clog2(CHUNKS+1)-1:0];
	assign diff      = now_q - rdl;
	assign rel_ok    = ({26'd0, item_q.release_slot} < 32'(SLOTS)) &&
		(sstate_q[item_q.release_slot[AW-1:0]] == efrt_pkg::SLOT_DONE);
	assign scan_end  = (idx_q == CW'(SLOTS));
	assign raddr     = (state_q == efrt_pkg::FSM_ARRIVE) ? found_q_a :
		(state_q == efrt_pkg::FSM_RELEASE) ? item_q.release_slot[AW-1:0] :
		idx_q[AW-1:0];

	assign in_ch.ready  = (state_q == efrt_pkg::FSM_IDLE) && !res_v_q;
	assign out_ch.valid = res_v_q;
	assign out_ch.data  = res_q;

	// next state and memory write
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = found_q_a;
		wid = item_q.event_id;
		wmap = rmap | bit_m;
		wdl = rdl;
		unique case (state_q)
			efrt_pkg::FSM_IDLE: begin
				if (in_ch.valid && in_ch.ready) begin
					unique case (efrt_pkg::op_t'(in_ch.data.operation))
						efrt_pkg::OP_CHUNK:   state_d = efrt_pkg::FSM_SCAN;
						efrt_pkg::OP_TICK:    state_d = efrt_pkg::FSM_TICK;
						efrt_pkg::OP_RELEASE: state_d = efrt_pkg::FSM_RELEASE;
						default:              state_d = efrt_pkg::FSM_IDLE;
					endcase
				end
			end
			efrt_pkg::FSM_SCAN: begin
				if (chunk_bad) state_d = efrt_pkg::FSM_OUT;
				else if (found_q) state_d = efrt_pkg::FSM_ARRIVE;
				else if (scan_end && !rd_v_q) begin
					if (!free_v_q) state_d = efrt_pkg::FSM_OUT;
					else begin
						// fresh allocation
						we = 1'b1;
						waddr = free_q_a;
						wmap = bit_m;
						wdl = now_q + {16'd0, timeout_q};
						state_d = efrt_pkg::FSM_OUT;
					end
				end
			end
			efrt_pkg::FSM_ARRIVE: begin
				if (rd_v_q) begin
					we = ((rmap & bit_m) == '0);
					state_d = efrt_pkg::FSM_OUT;
				end
			end
			efrt_pkg::FSM_TICK: begin
				if (scan_end && !rd_v_q && !more_q) state_d = efrt_pkg::FSM_OUT;
			end
			efrt_pkg::FSM_RELEASE: begin
				if (rd_v_q || !rel_ok) state_d = efrt_pkg::FSM_OUT;
			end
			efrt_pkg::FSM_OUT: begin
				if (!res_v_q) state_d = efrt_pkg::FSM_IDLE;
			end
			default: state_d = efrt_pkg::FSM_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= efrt_pkg::FSM_IDLE;
		else state_q <= state_d;
	end

	// datapath and slot state flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) sstate_q[i] <= efrt_pkg::SLOT_FREE;
			timeout_q <= 16'(efrt_pkg::TIMEOUT_RESET);
			now_q <= '0;
			idx_q <= '0;
			rd_v_q <= 1'b0;
			rd_a_q <= '0;
			found_q <= 1'b0;
			free_v_q <= 1'b0;
			found_q_a <= '0;
			free_q_a <= '0;
			more_q <= 1'b0;
			reap_q <= '0;
			res_v_q <= 1'b0;
			res_q <= '0;
			item_q <= '0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			if (out_ch.valid && out_ch.ready) res_v_q <= 1'b0;
			unique case (state_q)
				efrt_pkg::FSM_IDLE: begin
					idx_q <= '0;
					rd_v_q <= 1'b0;
					found_q <= 1'b0;
					free_v_q <= 1'b0;
					more_q <= 1'b0;
					if (in_ch.valid && in_ch.ready) begin
						item_q <= in_ch.data;
						if (in_ch.data.operation == efrt_pkg::OP_TICK) now_q <= now_q + 32'd1;
					end
				end
				efrt_pkg::FSM_SCAN: begin
					res_q <= '{status: 3'(efrt_pkg::ST_BAD_INDEX),
						event_id_res: item_q.event_id, slot: '0,
						chunk_index_res: item_q.chunk_index, last: 1'b1};
					if (!chunk_bad) begin
						// issue reads for slots in order; flags decide which need data
						if (!scan_end) begin
							idx_q <= idx_q + CW'(1);
							rd_a_q <= idx_q[AW-1:0];
							rd_v_q <= (sstate_q[idx_q[AW-1:0]] == efrt_pkg::SLOT_ASSEMBLING)
								&& !found_q;
							if (sstate_q[idx_q[AW-1:0]] == efrt_pkg::SLOT_FREE && !free_v_q
								&& !found_q) begin
								free_v_q <= 1'b1;
								free_q_a <= idx_q[AW-1:0];
							end
						end else rd_v_q <= 1'b0;
						if (rd_v_q && !found_q && rid == item_q.event_id) begin
							found_q <= 1'b1;
							found_q_a <= rd_a_q;
							rd_v_q <= 1'b0;
						end
						if (scan_end && !rd_v_q && !found_q) begin
							if (!free_v_q) res_q.status <= 3'(efrt_pkg::ST_NO_SLOT);
							else begin
								sstate_q[free_q_a] <= (CHUNKS == 1) ?
									efrt_pkg::SLOT_DONE : efrt_pkg::SLOT_ASSEMBLING;
								res_q.status <= (CHUNKS == 1) ? 3'(efrt_pkg::ST_COMPLETE)
									: 3'(efrt_pkg::ST_ACCEPTED);
								res_q.slot <= 6'(free_q_a);
							end
						end
					end
				end
				efrt_pkg::FSM_ARRIVE: begin
					rd_v_q <= 1'b1;
					if (rd_v_q) begin
						res_q.slot <= 6'(found_q_a);
						if ((rmap & bit_m) != '0) res_q.status <= 3'(efrt_pkg::ST_DUPLICATE);
						else if ((rmap | bit_m) == '1) begin
							res_q.status <= 3'(efrt_pkg::ST_COMPLETE);
							sstate_q[found_q_a] <= efrt_pkg::SLOT_DONE;
						end else res_q.status <= 3'(efrt_pkg::ST_ACCEPTED);
					end
				end
				efrt_pkg::FSM_TICK: begin
					// read an assembling slot, judge its deadline the next cycle;
					// the newest reaped item waits in reap_q until the next one shows or the scan ends
					if (rd_v_q) begin
						rd_v_q <= 1'b0;
						if (diff != '0 && !diff[31]) begin
							sstate_q[rd_a_q] <= efrt_pkg::SLOT_FREE;
							reap_q <= '{status: 3'(efrt_pkg::ST_REAPED), event_id_res: rid,
								slot: 6'(rd_a_q), chunk_index_res: '0, last: 1'b0};
							more_q <= 1'b1;
							if (more_q) begin
								res_q <= reap_q;
								res_v_q <= 1'b1;
							end
						end
					end else if (scan_end) begin
						// scan done: the held item is the last one
						if (more_q && !res_v_q) begin
							res_q <= '{status: reap_q.status,
								event_id_res: reap_q.event_id_res, slot: reap_q.slot,
								chunk_index_res: reap_q.chunk_index_res, last: 1'b1};
							res_v_q <= 1'b1;
							more_q <= 1'b0;
						end
					end else if (!more_q || !res_v_q) begin
						idx_q <= idx_q + CW'(1);
						rd_a_q <= idx_q[AW-1:0];
						rd_v_q <= (sstate_q[idx_q[AW-1:0]] == efrt_pkg::SLOT_ASSEMBLING);
					end
				end
				efrt_pkg::FSM_RELEASE: begin
					rd_v_q <= rel_ok;
					if (rd_v_q) begin
						sstate_q[item_q.release_slot[AW-1:0]] <= efrt_pkg::SLOT_FREE;
						res_q <= '{status: 3'(efrt_pkg::ST_RELEASED), event_id_res: rid,
							slot: item_q.release_slot, chunk_index_res: '0, last: 1'b1};
						res_v_q <= 1'b1;
					end
				end
				efrt_pkg::FSM_OUT: begin
					if (item_q.operation == efrt_pkg::OP_CHUNK && !res_v_q && !more_q) begin
						res_v_q <= 1'b1;
						more_q <= 1'b0;
						item_q.operation <= efrt_pkg::OP_NONE;
					end
				end
				default: ;
			endcase
		end
	end

	// a result is held while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result dropped under stall");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != efrt_pkg::FSM_IDLE |-> !in_ch.ready)
		else $error("item taken while busy");
	a_one_wr: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == efrt_pkg::FSM_SCAN || state_q == efrt_pkg::FSM_ARRIVE)
		else $error("record write outside arrival");
endmodule
